// File: sv/ipv4rx_pkg.sv
// ----------------------------------------------------------------------------
// ipv4rx_pkg
// Shared types and constants for the IPv4 receive header check: register
// indexes, verdict codes, the frame record that crosses the queue and the
// configuration bundle.
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

  // protocol handler slots in use, and slots the register map provides
  localparam int HANDLER_SLOTS = 4;
  localparam int CFG_SLOTS     = 4;
  localparam int ACTIVE_SLOTS  = (HANDLER_SLOTS < CFG_SLOTS) ? HANDLER_SLOTS : CFG_SLOTS;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int VERDICT_W  = 4;
  localparam int HANDLER_W  = 2;
  localparam int HDR_W      = 6;
  localparam int LEN_W      = 16;
  localparam int ADDR_W     = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_UNICAST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_BROADCAST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_SLOT0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_SLOT1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_SLOT2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_SLOT3     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_ENABLE    = 3'd6;

  // verdict codes, first failing check wins
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPT     = 4'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_SHORT      = 4'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_VERSION    = 4'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_HDR_CUT    = 4'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_TOTAL_LONG = 4'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_CHECKSUM   = 4'd5;
  localparam logic [VERDICT_W-1:0] VERDICT_FRAGMENT   = 4'd6;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_OURS   = 4'd7;
  localparam logic [VERDICT_W-1:0] VERDICT_UNK_PROTO  = 4'd8;

  // header constants
  localparam logic [3:0]        IP_VERSION4  = 4'd4;
  localparam logic [LEN_W-1:0]  MIN_HDR_LEN  = 16'd20;
  localparam logic [15:0]       SUM_GOOD     = 16'hffff;
  localparam logic [15:0]       MF_MASK      = 16'h2000;
  localparam logic [15:0]       OFFSET_MASK  = 16'h1fff;
  localparam logic [ADDR_W-1:0] ALL_ONES     = 32'hffffffff;

  // summary of one finished frame
  typedef struct packed {
    logic [LEN_W-1:0]  frame_len;
    logic [7:0]        ver_ihl;
    logic [LEN_W-1:0]  total_len;
    logic [15:0]       csum;
    logic [15:0]       flags_off;
    logic [7:0]        proto;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
  } frame_rec_t;

  // configuration registers
  typedef struct packed {
    logic [ADDR_W-1:0]               local_unicast;
    logic [ADDR_W-1:0]               local_broadcast;
    logic [CFG_SLOTS-1:0][7:0]       proto_slot;
    logic [CFG_SLOTS-1:0]            proto_enable;
  } cfg_t;

endpackage

// File: sv/ipv4rx_front.sv
// ----------------------------------------------------------------------------
// ipv4rx_front
// Byte parser: counts frame bytes, latches header fields and keeps the
// running one's-complement sum. At the last byte it pushes a frame record.
// ----------------------------------------------------------------------------
module ipv4rx_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_frame_byte,
  input  logic                   in_frame_end,
  input  logic                   q_full,
  output logic                   q_push,
  output ipv4rx_pkg::frame_rec_t q_rec
);
  import ipv4rx_pkg::*;

  localparam logic [LEN_W-1:0] POS_MAX = 16'hffff;

  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [15:0]       sum_r, sum_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [7:0]        verihl_r, verihl_nxt;
  logic [LEN_W-1:0]  tot_r, tot_nxt;
  logic [15:0]       flg_r, flg_nxt;
  logic [7:0]        proto_r, proto_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;

  logic [HDR_W-1:0]  hlen;
  logic [16:0]       sum_raw;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && in_frame_end;

  // per-byte update of the header state
  always_comb begin
    verihl_nxt = (pos_r == '0) ? in_frame_byte : verihl_r;
    hlen       = {verihl_nxt[3:0], 2'b00};
    sum_nxt    = sum_r;
    pend_nxt   = pend_r;
    tot_nxt    = tot_r;
    flg_nxt    = flg_r;
    proto_nxt  = proto_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;

    // word sum with end-around carry over the first IHL*4 bytes
    sum_raw = {1'b0, sum_r} + {1'b0, pend_r, in_frame_byte};
    if (pos_r < {{(LEN_W-HDR_W){1'b0}}, hlen}) begin
      if (pos_r[0]) begin
        sum_nxt = sum_raw[15:0] + {15'b0, sum_raw[16]};
      end else begin
        pend_nxt = in_frame_byte;
      end
    end

    // field latches
    if (pos_r == 16'd2 || pos_r == 16'd3) begin
      tot_nxt = {tot_r[7:0], in_frame_byte};
    end else if (pos_r == 16'd6 || pos_r == 16'd7) begin
      flg_nxt = {flg_r[7:0], in_frame_byte};
    end else if (pos_r == 16'd9) begin
      proto_nxt = in_frame_byte;
    end else if (pos_r >= 16'd12 && pos_r <= 16'd15) begin
      src_nxt = {src_r[ADDR_W-9:0], in_frame_byte};
    end else if (pos_r >= 16'd16 && pos_r <= 16'd19) begin
      dst_nxt = {dst_r[ADDR_W-9:0], in_frame_byte};
    end

    // saturating byte count
    pos_nxt = (pos_r != POS_MAX) ? pos_r + 16'd1 : pos_r;
  end

  // record of the finished frame
  always_comb begin
    q_rec.frame_len = pos_nxt;
    q_rec.ver_ihl   = verihl_nxt;
    q_rec.total_len = tot_nxt;
    q_rec.csum      = sum_nxt;
    q_rec.flags_off = flg_nxt;
    q_rec.proto     = proto_nxt;
    q_rec.src       = src_nxt;
    q_rec.dst       = dst_nxt;
  end

  // state registers, cleared after each frame
  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      pos_r    <= '0;
      sum_r    <= '0;
      pend_r   <= '0;
      verihl_r <= '0;
      tot_r    <= '0;
      flg_r    <= '0;
      proto_r  <= '0;
      src_r    <= '0;
      dst_r    <= '0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      pend_r   <= pend_nxt;
      verihl_r <= verihl_nxt;
      tot_r    <= tot_nxt;
      flg_r    <= flg_nxt;
      proto_r  <= proto_nxt;
      src_r    <= src_nxt;
      dst_r    <= dst_nxt;
    end
  end

endmodule

// File: sv/ipv4rx_queue.sv
// ----------------------------------------------------------------------------
// ipv4rx_queue
// Short FIFO of frame records between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module ipv4rx_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ipv4rx_pkg::frame_rec_t rec_in,
  input  logic                   pop,
  output ipv4rx_pkg::frame_rec_t rec_out,
  output logic                   not_empty,
  output logic                   full
);
  import ipv4rx_pkg::*;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  frame_rec_t        entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign rec_out   = entry_r[rd_ptr_r];

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= rec_in;
    end
  end

endmodule

// File: sv/ipv4rx_back.sv
// ----------------------------------------------------------------------------
// ipv4rx_back
// Verdict stage: takes one frame record, runs the ordered checks and the
// protocol slot lookup, and holds the result in the output register.
// ----------------------------------------------------------------------------
module ipv4rx_back (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ipv4rx_pkg::cfg_t                       cfg,
  input  logic                                   q_valid,
  input  ipv4rx_pkg::frame_rec_t                 q_rec,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [ipv4rx_pkg::VERDICT_W-1:0]       out_verdict,
  output logic [ipv4rx_pkg::HANDLER_W-1:0]       out_handler_index,
  output logic [ipv4rx_pkg::HDR_W-1:0]           out_header_bytes,
  output logic [ipv4rx_pkg::LEN_W-1:0]           out_payload_bytes,
  output logic [ipv4rx_pkg::ADDR_W-1:0]          out_source_address,
  output logic [ipv4rx_pkg::ADDR_W-1:0]          out_destination_address
);
  import ipv4rx_pkg::*;

  logic                 valid_r;
  logic [VERDICT_W-1:0] verdict_r, verdict_nxt;
  logic [HANDLER_W-1:0] handler_r, handler_nxt;
  logic [HDR_W-1:0]     hdr_r, hdr_nxt;
  logic [LEN_W-1:0]     payload_r, payload_nxt;
  logic [ADDR_W-1:0]    src_r, dst_r;

  logic [LEN_W-1:0]     hlen_ext;
  logic                 proto_hit;
  logic [HANDLER_W-1:0] proto_slot_sel;
  logic                 dst_ok;

  assign q_pop = q_valid && (!valid_r || !out_stall);

  // lowest enabled slot with a matching protocol number
  always_comb begin
    proto_hit      = 1'b0;
    proto_slot_sel = '0;
    for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
      if (cfg.proto_enable[i] && cfg.proto_slot[i] == q_rec.proto) begin
        proto_hit      = 1'b1;
        proto_slot_sel = HANDLER_W'(i);
      end
    end
  end

  // ordered checks
  always_comb begin
    hdr_nxt  = {q_rec.ver_ihl[3:0], 2'b00};
    hlen_ext = {{(LEN_W-HDR_W){1'b0}}, hdr_nxt};
    dst_ok   = (q_rec.dst == cfg.local_unicast) || (q_rec.dst == ALL_ONES) ||
               (q_rec.dst == cfg.local_broadcast);
    handler_nxt = '0;
    if (q_rec.frame_len < MIN_HDR_LEN) begin
      verdict_nxt = VERDICT_SHORT;
    end else if (q_rec.ver_ihl[7:4] != IP_VERSION4) begin
      verdict_nxt = VERDICT_VERSION;
    end else if (q_rec.frame_len < hlen_ext) begin
      verdict_nxt = VERDICT_HDR_CUT;
    end else if (q_rec.frame_len < q_rec.total_len) begin
      verdict_nxt = VERDICT_TOTAL_LONG;
    end else if (q_rec.csum != SUM_GOOD) begin
      verdict_nxt = VERDICT_CHECKSUM;
    end else if ((q_rec.flags_off & (MF_MASK | OFFSET_MASK)) != '0) begin
      verdict_nxt = VERDICT_FRAGMENT;
    end else if (!dst_ok) begin
      verdict_nxt = VERDICT_NOT_OURS;
    end else if (!proto_hit) begin
      verdict_nxt = VERDICT_UNK_PROTO;
    end else begin
      verdict_nxt = VERDICT_ACCEPT;
      handler_nxt = proto_slot_sel;
    end
    // payload length, floored at zero
    payload_nxt = (q_rec.total_len > hlen_ext) ? q_rec.total_len - hlen_ext : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      verdict_r <= verdict_nxt;
      handler_r <= handler_nxt;
      hdr_r     <= hdr_nxt;
      payload_r <= payload_nxt;
      src_r     <= q_rec.src;
      dst_r     <= q_rec.dst;
    end
  end

  assign out_valid               = valid_r;
  assign out_verdict             = verdict_r;
  assign out_handler_index       = handler_r;
  assign out_header_bytes        = hdr_r;
  assign out_payload_bytes       = payload_r;
  assign out_source_address      = src_r;
  assign out_destination_address = dst_r;

endmodule

// File: sv/ipv4_receive_header_check.sv
// A frame's record is written into the queue at its last byte and later popped into the output register.
// Throughput: one frame byte per cycle while the queue is not full; the parser runs at byte rate and the
//   verdict stage retires one frame record per cycle, unless the output stalls, from a two-entry queue.
// Input stalls only while that queue is full, output stalls back up into it.
// Reset (synchronous, rst_n low) clears the byte count, header state, queue,
//   output valid and all configuration registers to zero.
// ----------------------------------------------------------------------------
// ipv4_receive_header_check
// IPv4 receive header check: parses a byte-wide frame, checks length,
// version, checksum, fragmentation, destination and protocol, and gives one
// verdict item per frame.
// ----------------------------------------------------------------------------
module ipv4_receive_header_check (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipv4rx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipv4rx_pkg::CFG_DATA_W-1:0]     cfg_data,
  // frame bytes
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            in_frame_byte,
  input  logic                                  in_frame_end,
  // verdict items
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ipv4rx_pkg::VERDICT_W-1:0]      out_verdict,
  output logic [ipv4rx_pkg::HANDLER_W-1:0]      out_handler_index,
  output logic [ipv4rx_pkg::HDR_W-1:0]          out_header_bytes,
  output logic [ipv4rx_pkg::LEN_W-1:0]          out_payload_bytes,
  output logic [ipv4rx_pkg::ADDR_W-1:0]         out_source_address,
  output logic [ipv4rx_pkg::ADDR_W-1:0]         out_destination_address
);
  import ipv4rx_pkg::*;

  cfg_t       cfg_r;
  frame_rec_t push_rec, pop_rec;
  logic       q_push, q_pop, q_full, q_not_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOCAL_UNICAST:   cfg_r.local_unicast   <= cfg_data;
        REG_LOCAL_BROADCAST: cfg_r.local_broadcast <= cfg_data;
        REG_PROTO_SLOT0:     cfg_r.proto_slot[0]   <= cfg_data[7:0];
        REG_PROTO_SLOT1:     cfg_r.proto_slot[1]   <= cfg_data[7:0];
        REG_PROTO_SLOT2:     cfg_r.proto_slot[2]   <= cfg_data[7:0];
        REG_PROTO_SLOT3:     cfg_r.proto_slot[3]   <= cfg_data[7:0];
        REG_PROTO_ENABLE:    cfg_r.proto_enable    <= cfg_data[CFG_SLOTS-1:0];
        default: ;
      endcase
    end
  end

  ipv4rx_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_rec         (push_rec)
  );

  ipv4rx_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .rec_in    (push_rec),
    .pop       (q_pop),
    .rec_out   (pop_rec),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  ipv4rx_back u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg                     (cfg_r),
    .q_valid                 (q_not_empty),
    .q_rec                   (pop_rec),
    .q_pop                   (q_pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_verdict             (out_verdict),
    .out_handler_index       (out_handler_index),
    .out_header_bytes        (out_header_bytes),
    .out_payload_bytes       (out_payload_bytes),
    .out_source_address      (out_source_address),
    .out_destination_address (out_destination_address)
  );

  // a frame record is never dropped at a full queue
  assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
    else $error("frame record pushed into full queue");

  // handler index only reported on accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict != VERDICT_ACCEPT) |-> (out_handler_index == '0))
    else $error("handler index set on rejected frame");

  // a record popped from the queue is shown at the output on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> out_valid)
    else $error("popped frame record not presented");

  // header length is always whole 32-bit words
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_header_bytes[1:0] == 2'b00))
    else $error("header length not a multiple of four");

endmodule
